@@ hdl/svbph_pkg.sv @@
// ----------------------------------------------------------------------------
// svbph_pkg
// Shared types, constants and helpers for the stereo meter ballistics block.
// ----------------------------------------------------------------------------
package svbph_pkg;

    localparam int LEVEL_W  = 16;
    localparam int BAR_W    = 10;
    localparam int PEAK_W   = 11;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int NUM_W    = 28;
    localparam int DEN_W    = 17;
    localparam int QUOT_W   = BAR_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Level used when a sample is flagged non-finite: -120 dB in Q8.8.
    localparam logic signed [LEVEL_W-1:0] LEVEL_NONFINITE = -16'sd30720;

    localparam logic signed [LEVEL_W-1:0] OFFSET_RST  = 16'sd0;
    localparam logic signed [LEVEL_W-1:0] FLOOR_RST   = -16'sd10240;
    localparam logic signed [LEVEL_W-1:0] CEILING_RST = 16'sd768;
    localparam logic [BAR_W-1:0]          LENGTH_RST  = 10'd274;
    localparam logic [BAR_W-1:0]          ATTACK_RST  = 10'd50;
    localparam logic [BAR_W-1:0]          RELEASE_RST = 10'd8;
    localparam logic [MS_W-1:0]           PERIOD_RST  = 16'd16;
    localparam logic [MS_W-1:0]           HOLD_RST    = 16'd1000;

    localparam logic signed [PEAK_W-1:0]  MARKER_NONE = -11'sd1;

    typedef enum logic [2:0] {
        REG_OFFSET  = 3'd0,
        REG_FLOOR   = 3'd1,
        REG_CEILING = 3'd2,
        REG_LENGTH  = 3'd3,
        REG_ATTACK  = 3'd4,
        REG_RELEASE = 3'd5,
        REG_PERIOD  = 3'd6,
        REG_HOLD    = 3'd7
    } reg_idx_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_FRAME  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_DIV,
        S_FRAME,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // True once now has reached mark, safe across a wrap of the counter.
    function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] mark);
        logic [TIME_W-1:0] diff;
        begin
            diff = now - mark;
            time_reached = ~diff[TIME_W-1];
        end
    endfunction

endpackage

@@ hdl/svbph_if.sv @@
// ----------------------------------------------------------------------------
// svbph_if
// Valid/ready channels for meter commands and meter results.
// ----------------------------------------------------------------------------
interface svbph_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic signed [svbph_pkg::LEVEL_W-1:0]  left_level;
    logic signed [svbph_pkg::LEVEL_W-1:0]  right_level;
    logic                                  left_finite;
    logic                                  right_finite;
    logic [svbph_pkg::TIME_W-1:0]          now_ms;

    modport source (output valid, command, left_level, right_level, left_finite,
                    right_finite, now_ms, input ready);
    modport sink (input valid, command, left_level, right_level, left_finite,
                  right_finite, now_ms, output ready);
endinterface

interface svbph_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [svbph_pkg::BAR_W-1:0]           left_bar;
    logic signed [svbph_pkg::PEAK_W-1:0]   left_peak;
    logic [svbph_pkg::BAR_W-1:0]           right_bar;
    logic signed [svbph_pkg::PEAK_W-1:0]   right_peak;

    modport source (output valid, left_bar, left_peak, right_bar, right_peak,
                    input ready);
    modport sink (input valid, left_bar, left_peak, right_bar, right_peak,
                  output ready);
endinterface

@@ hdl/stereo_vu_ballistics_peak_hold_top.sv @@
// ----------------------------------------------------------------------------
// stereo_vu_ballistics_peak_hold_top
// Two-channel level meter ballistics with attack limit, timed release and
// peak hold.
// ----------------------------------------------------------------------------
// Usage:
//   meter_in carries one command per transaction. A level sample (command 0)
//   maps both levels to target bar lengths and returns nothing. A frame
//   (command 1) moves the bars toward their targets, updates the peak
//   markers, returns one transaction on meter_out and then applies the timed
//   release decay.
//   A sample keeps the sequencer busy while each channel in turn goes
//   through the offset, clamp and multiply step, the shared restoring
//   divider and a step to store its target. A frame keeps it busy for
//   one step per channel in the shared frame update and one to load the
//   result register.
//   meter_in.ready is high only while the sequencer is idle.
//   The result register parts the two sides: a new command is taken while a
//   result still waits. A frame that finds the result register full waits
//   in its emit step until meter_out takes the pending transaction.
//   Reset restores all registers to their defaults, clears bars and targets,
//   removes both peak markers and clears the decay time mark.
//   The APB port is always ready; write registers only while idle.
// ----------------------------------------------------------------------------
module stereo_vu_ballistics_peak_hold_top (
    input  logic                          clk,
    input  logic                          rst_n,
    svbph_in_if.sink                      meter_in,
    svbph_out_if.source                   meter_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svbph_pkg::ADDR_W-1:0]  paddr,
    input  logic [svbph_pkg::DATA_W-1:0]  pwdata,
    output logic [svbph_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import svbph_pkg::*;

    // Configuration registers
    logic signed [LEVEL_W-1:0] offset_reg;
    logic signed [LEVEL_W-1:0] floor_reg;
    logic signed [LEVEL_W-1:0] ceiling_reg;
    logic [BAR_W-1:0]          length_reg;
    logic [BAR_W-1:0]          attack_reg;
    logic [BAR_W-1:0]          release_reg;
    logic [MS_W-1:0]           period_reg;
    logic [MS_W-1:0]           hold_reg;

    reg_idx_t                  cfg_idx;
    logic                      cfg_write;

    // Sequencer and captured command
    state_t                    state_reg;
    state_t                    state_next;
    logic                      chan_reg;
    logic signed [LEVEL_W-1:0] level_reg [2];
    logic                      finite_reg [2];
    logic [TIME_W-1:0]         now_reg;

    // Meter state
    logic [BAR_W-1:0]          target_reg [2];
    logic [BAR_W-1:0]          shown_reg [2];
    logic signed [PEAK_W-1:0]  marker_reg [2];
    logic [TIME_W-1:0]         expiry_reg [2];
    logic [TIME_W-1:0]         next_decay_reg;

    // Result register
    logic                      out_valid_reg;
    logic [BAR_W-1:0]          out_lbar_reg;
    logic signed [PEAK_W-1:0]  out_lpeak_reg;
    logic [BAR_W-1:0]          out_rbar_reg;
    logic signed [PEAK_W-1:0]  out_rpeak_reg;

    // Divider link
    div_cmd_t                  div_cmd;
    div_stat_t                 div_stat;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [QUOT_W-1:0]         div_quot;

    // Mapping datapath
    logic signed [DEN_W-1:0]   span;
    logic                      span_ok;
    logic signed [LEVEL_W-1:0] level_sel;
    logic signed [DEN_W:0]     level_sum;
    logic signed [DEN_W:0]     level_clamp;
    logic signed [DEN_W:0]     level_rel;
    logic [LEVEL_W+BAR_W-1:0]  product;

    // Frame datapath
    logic [BAR_W-1:0]          tgt_lim;
    logic [BAR_W-1:0]          rise;
    logic [BAR_W-1:0]          shown_new;
    logic signed [PEAK_W:0]    shown_minus1;
    logic signed [PEAK_W-1:0]  marker_new;
    logic [TIME_W-1:0]         expiry_new;
    logic                      emit_go;
    logic                      decay_due;
    logic                      in_accept;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= OFFSET_RST;
            floor_reg   <= FLOOR_RST;
            ceiling_reg <= CEILING_RST;
            length_reg  <= LENGTH_RST;
            attack_reg  <= ATTACK_RST;
            release_reg <= RELEASE_RST;
            period_reg  <= PERIOD_RST;
            hold_reg    <= HOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_OFFSET:  offset_reg  <= pwdata[LEVEL_W-1:0];
                REG_FLOOR:   floor_reg   <= pwdata[LEVEL_W-1:0];
                REG_CEILING: ceiling_reg <= pwdata[LEVEL_W-1:0];
                REG_LENGTH:  length_reg  <= pwdata[BAR_W-1:0];
                REG_ATTACK:  attack_reg  <= pwdata[BAR_W-1:0];
                REG_RELEASE: release_reg <= pwdata[BAR_W-1:0];
                REG_PERIOD:  period_reg  <= pwdata[MS_W-1:0];
                REG_HOLD:    hold_reg    <= pwdata[MS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_OFFSET:  prdata = {{(DATA_W-LEVEL_W){1'b0}}, offset_reg};
            REG_FLOOR:   prdata = {{(DATA_W-LEVEL_W){1'b0}}, floor_reg};
            REG_CEILING: prdata = {{(DATA_W-LEVEL_W){1'b0}}, ceiling_reg};
            REG_LENGTH:  prdata = {{(DATA_W-BAR_W){1'b0}}, length_reg};
            REG_ATTACK:  prdata = {{(DATA_W-BAR_W){1'b0}}, attack_reg};
            REG_RELEASE: prdata = {{(DATA_W-BAR_W){1'b0}}, release_reg};
            REG_PERIOD:  prdata = {{(DATA_W-MS_W){1'b0}}, period_reg};
            REG_HOLD:    prdata = {{(DATA_W-MS_W){1'b0}}, hold_reg};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Level mapping: offset, clamp, multiply; the divider finishes it.
    // ------------------------------------------------------------------
    assign span    = DEN_W'(ceiling_reg) - DEN_W'(floor_reg);
    assign span_ok = (span > 0);

    always_comb
    begin
        level_sel   = finite_reg[chan_reg] ? level_reg[chan_reg] : LEVEL_NONFINITE;
        level_sum   = (DEN_W+1)'(level_sel) + (DEN_W+1)'(offset_reg);
        if (level_sum > (DEN_W+1)'(ceiling_reg))
        begin
            level_clamp = (DEN_W+1)'(ceiling_reg);
        end
        else if (level_sum < (DEN_W+1)'(floor_reg))
        begin
            level_clamp = (DEN_W+1)'(floor_reg);
        end
        else
        begin
            level_clamp = level_sum;
        end
        level_rel = level_clamp - (DEN_W+1)'(floor_reg);
        product   = level_rel[LEVEL_W-1:0] * length_reg;
        div_num   = {1'b0, product, 1'b0} + NUM_W'(span[LEVEL_W-1:0]);
        div_den   = {span[LEVEL_W-1:0], 1'b0};
    end

    svbph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Frame update for the channel under chan_reg
    // ------------------------------------------------------------------
    always_comb
    begin
        tgt_lim = (target_reg[chan_reg] > length_reg) ? length_reg : target_reg[chan_reg];
        rise    = tgt_lim - shown_reg[chan_reg];
        if (tgt_lim > shown_reg[chan_reg])
        begin
            shown_new = shown_reg[chan_reg] + ((rise > attack_reg) ? attack_reg : rise);
        end
        else
        begin
            shown_new = shown_reg[chan_reg];
        end
        shown_minus1 = $signed({2'b00, shown_new}) - 12'sd1;
        marker_new   = marker_reg[chan_reg];
        expiry_new   = expiry_reg[chan_reg];
        if (shown_minus1 > (PEAK_W+1)'(marker_reg[chan_reg]))
        begin
            marker_new = shown_minus1[PEAK_W-1:0];
            expiry_new = now_reg + TIME_W'(hold_reg);
        end
        else if (!marker_reg[chan_reg][PEAK_W-1]
                 && time_reached(now_reg, expiry_reg[chan_reg])
                 && ($signed({2'b00, shown_new}) <= (PEAK_W+1)'(marker_reg[chan_reg])))
        begin
            marker_new = MARKER_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign meter_in.ready = (state_reg == S_IDLE);
    assign in_accept      = meter_in.valid && meter_in.ready;
    assign emit_go        = (state_reg == S_EMIT) && (!out_valid_reg || meter_out.ready);
    assign decay_due      = time_reached(now_reg, next_decay_reg);

    always_comb
    begin
        state_next    = state_reg;
        div_cmd.start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (meter_in.command == CMD_FRAME) ? S_FRAME : S_MAP;
                end
            end
            S_MAP:
            begin
                div_cmd.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = chan_reg ? S_IDLE : S_MAP;
                end
            end
            S_FRAME:
            begin
                if (chan_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                chan_reg <= 1'b0;
            end
            else if ((state_reg == S_DIV && div_stat.done) || state_reg == S_FRAME)
            begin
                chan_reg <= ~chan_reg;
            end
        end
    end

    // Captured command fields
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg[0]  <= meter_in.left_level;
            level_reg[1]  <= meter_in.right_level;
            finite_reg[0] <= meter_in.left_finite;
            finite_reg[1] <= meter_in.right_finite;
            now_reg       <= meter_in.now_ms;
        end
    end

    // Meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                target_reg[i] <= '0;
                shown_reg[i]  <= '0;
                marker_reg[i] <= MARKER_NONE;
                expiry_reg[i] <= '0;
            end
            next_decay_reg <= '0;
        end
        else
        begin
            if (state_reg == S_DIV && div_stat.done)
            begin
                target_reg[chan_reg] <= span_ok ? div_quot : '0;
            end
            if (state_reg == S_FRAME)
            begin
                shown_reg[chan_reg]  <= shown_new;
                marker_reg[chan_reg] <= marker_new;
                expiry_reg[chan_reg] <= expiry_new;
            end
            if (emit_go && decay_due)
            begin
                next_decay_reg <= now_reg + TIME_W'(period_reg);
                for (int i = 0; i < 2; i++)
                begin
                    shown_reg[i] <= (shown_reg[i] > release_reg)
                                    ? shown_reg[i] - release_reg : '0;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (meter_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_lbar_reg  <= shown_reg[0];
            out_lpeak_reg <= marker_reg[0];
            out_rbar_reg  <= shown_reg[1];
            out_rpeak_reg <= marker_reg[1];
        end
    end

    assign meter_out.valid      = out_valid_reg;
    assign meter_out.left_bar   = out_lbar_reg;
    assign meter_out.left_peak  = out_lpeak_reg;
    assign meter_out.right_bar  = out_rbar_reg;
    assign meter_out.right_peak = out_rpeak_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start the sequencer");

    a_marker_range: assert property (@(posedge clk) disable iff (!rst_n)
        marker_reg[0][PEAK_W-1] |-> (marker_reg[0] == MARKER_NONE))
        else $error("left peak marker below -1");

endmodule

@@ hdl/svbph_div.sv @@
// ----------------------------------------------------------------------------
// svbph_div
// Restoring divider, one quotient bit per cycle, for the level-to-length map.
// ----------------------------------------------------------------------------
module svbph_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  svbph_pkg::div_cmd_t           cmd,
    input  logic [svbph_pkg::NUM_W-1:0]   num,
    input  logic [svbph_pkg::DEN_W-1:0]   den,
    output svbph_pkg::div_stat_t          stat,
    output logic [svbph_pkg::QUOT_W-1:0]  quot
);
    import svbph_pkg::*;

    localparam int DSH_W = DEN_W + QUOT_W - 1;
    localparam int CNT_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  dsh_ext;
    logic              fits;

    // The caller guarantees the quotient fits in QUOT_W bits.
    assign dsh_ext = {{(NUM_W-DSH_W){1'b0}}, dsh_reg};
    assign fits    = (rem_reg >= dsh_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg  <= num;
            dsh_reg  <= {den, {(QUOT_W-1){1'b0}}};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_ext;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule
